// ----- src/mds_pkg.sv -----
`default_nettype none

package mds_pkg;

	localparam int MAX_STATES = 8;
	localparam int STATE_W    = 3;
	localparam int NUM_W      = 4;
	localparam int RAND_W     = 16;
	localparam int PROB_W     = 17;
	localparam int POS_W      = 32;
	localparam int CNT_W      = 32;
	localparam int TOT_W      = 48;

	// 2.0 in the fraction format, one bit wider than a table entry
	localparam logic [PROB_W:0] TWO_FRAC = (PROB_W + 1)'(131072);

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	typedef logic [STATE_W-1:0] state_t;
	typedef logic [PROB_W-1:0]  prob_t;
	typedef logic [MAX_STATES-1:0][PROB_W-1:0] row_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [TOT_W-1:0] total;
	} stats_t;

	typedef struct packed {
		state_t           current_state;
		logic             dwell_done;
		state_t           ended_state;
		logic [POS_W-1:0] dwell_start;
		logic [POS_W-1:0] dwell_length;
		logic [CNT_W-1:0] event_count;
		logic [TOT_W-1:0] total_dwell;
	} rsp_t;

endpackage

`default_nettype wire

// ----- src/mds_if.sv -----
`default_nettype none

interface mds_req_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [mds_pkg::RAND_W-1:0]  stay_random;
	logic [mds_pkg::RAND_W-1:0]  jump_random;
	logic [mds_pkg::STATE_W-1:0] load_row;
	logic [mds_pkg::STATE_W-1:0] load_col;
	logic [mds_pkg::PROB_W-1:0]  load_value;

	modport source (output valid, kind, stay_random, jump_random, load_row, load_col,
		load_value, input ready);
	modport sink (input valid, kind, stay_random, jump_random, load_row, load_col,
		load_value, output ready);
endinterface

interface mds_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [mds_pkg::STATE_W-1:0] current_state;
	logic                        dwell_done;
	logic [mds_pkg::STATE_W-1:0] ended_state;
	logic [mds_pkg::POS_W-1:0]   dwell_start;
	logic [mds_pkg::POS_W-1:0]   dwell_length;
	logic [mds_pkg::CNT_W-1:0]   event_count;
	logic [mds_pkg::TOT_W-1:0]   total_dwell;

	modport source (output valid, current_state, dwell_done, ended_state, dwell_start,
		dwell_length, event_count, total_dwell, input ready);
	modport sink (input valid, current_state, dwell_done, ended_state, dwell_start,
		dwell_length, event_count, total_dwell, output ready);
endinterface

`default_nettype wire

// ----- src/markov_dwell_simulator.sv -----
`default_nettype none

// Discrete-time Markov chain sampler with per-state dwell statistics. In the
// accept cycle of a request the transition row and the statistics entry of
// the present state are read from their memories; in the cycle that completes
// the request the stay test and the parallel jump search run, the memories are
// written back and the result is loaded into the output register. A stalled
// response delays that completion. A new request is taken in the cycle after
// the previous one completes, so the block does not take a new request before
// it is through with the last one. Statistics start at zero through per-entry
// valid bits, so no clearing pass follows reset. Table entries read before
// they are loaded give undefined results.
module markov_dwell_simulator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mds_pkg::NUM_W-1:0]  cfg_wdata,
	mds_req_if.sink                    req,
	mds_rsp_if.source                  rsp
);

	// control state
	logic [mds_pkg::NUM_W-1:0]      num_states_q;
	mds_pkg::state_t                state_q;
	logic [mds_pkg::POS_W-1:0]      tick_q;
	logic [mds_pkg::POS_W-1:0]      begin_q;
	logic                           busy_q;
	logic                           rsp_valid_q;
	logic [mds_pkg::MAX_STATES-1:0] stats_vld_q;

	// stage 1 request and memory read data
	logic                           kind_s1;
	logic [mds_pkg::RAND_W-1:0]     stay_s1;
	logic [mds_pkg::RAND_W-1:0]     jump_s1;
	mds_pkg::state_t                row_s1;
	mds_pkg::state_t                col_s1;
	mds_pkg::prob_t                 val_s1;
	mds_pkg::row_t                  trow_s1;
	mds_pkg::stats_t                stats_s1;
	logic                           stats_vld_s1;

	mds_pkg::rsp_t                  out_q;
	mds_pkg::rsp_t                  out_d;

	mds_pkg::row_t                  table_mem [mds_pkg::MAX_STATES];
	mds_pkg::stats_t                stats_mem [mds_pkg::MAX_STATES];

	logic                           accept;
	logic                           done_s1;
	logic                           is_tick;
	logic [mds_pkg::NUM_W-1:0]      n_use;
	mds_pkg::state_t                last_st;
	mds_pkg::state_t                fallback;
	mds_pkg::prob_t                 diag;
	logic [mds_pkg::PROB_W-1:0]     stay2;
	logic [mds_pkg::PROB_W:0]       stay_sum;
	logic                           stay;
	logic [mds_pkg::MAX_STATES-1:0] hit;
	logic                           found;
	mds_pkg::state_t                pick;
	mds_pkg::state_t                next_st;
	logic                           moved;
	logic [mds_pkg::POS_W-1:0]      len;
	mds_pkg::stats_t                stats_cur;
	mds_pkg::stats_t                stats_new;
	logic [mds_pkg::TOT_W:0]        tot_sum;

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign done_s1   = busy_q && (!rsp_valid_q || rsp.ready);
	assign is_tick   = (kind_s1 == mds_pkg::KIND_TICK);

	always_comb begin
		n_use = num_states_q;
		if (n_use < mds_pkg::NUM_W'(2)) n_use = mds_pkg::NUM_W'(2);
		if (n_use > mds_pkg::NUM_W'(mds_pkg::MAX_STATES)) n_use = mds_pkg::NUM_W'(mds_pkg::MAX_STATES);
	end

	assign last_st  = mds_pkg::STATE_W'(n_use - mds_pkg::NUM_W'(1));
	assign fallback = (state_q == last_st) ? last_st - mds_pkg::STATE_W'(1) : last_st;

	// stay when the random lies within half the stay probability of either end
	assign diag     = trow_s1[state_q];
	assign stay2    = {stay_s1, 1'b0};
	assign stay_sum = {1'b0, stay2} + {1'b0, diag};
	assign stay     = (stay_sum >= mds_pkg::TWO_FRAC) || (stay2 <= diag);

	always_comb begin
		for (int i = 0; i < mds_pkg::MAX_STATES; i++) begin
			hit[i] = (mds_pkg::NUM_W'(i) < n_use) && (mds_pkg::STATE_W'(i) != state_q) &&
				(trow_s1[i] >= {1'b0, jump_s1});
		end
	end

	// lowest qualifying column wins
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int i = mds_pkg::MAX_STATES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found = 1'b1;
				pick  = mds_pkg::STATE_W'(i);
			end
		end
	end

	assign next_st = stay ? state_q : (found ? pick : fallback);
	assign moved   = (next_st != state_q);
	assign len     = tick_q - begin_q;

	assign stats_cur = stats_vld_s1 ? stats_s1 : '0;
	assign tot_sum   = {1'b0, stats_cur.total} + (mds_pkg::TOT_W + 1)'(len);

	always_comb begin
		stats_new.count = (&stats_cur.count) ? stats_cur.count
			: stats_cur.count + mds_pkg::CNT_W'(1);
		stats_new.total = tot_sum[mds_pkg::TOT_W] ? '1 : tot_sum[mds_pkg::TOT_W-1:0];
	end

	always_comb begin
		out_d = '0;
		out_d.current_state = is_tick ? next_st : state_q;
		if (is_tick && moved) begin
			out_d.dwell_done   = 1'b1;
			out_d.ended_state  = state_q;
			out_d.dwell_start  = begin_q;
			out_d.dwell_length = len;
			out_d.event_count  = stats_new.count;
			out_d.total_dwell  = stats_new.total;
		end
	end

	// memories and stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1      <= req.kind;
			stay_s1      <= req.stay_random;
			jump_s1      <= req.jump_random;
			row_s1       <= req.load_row;
			col_s1       <= req.load_col;
			val_s1       <= req.load_value;
			trow_s1      <= table_mem[state_q];
			stats_s1     <= stats_mem[state_q];
			stats_vld_s1 <= stats_vld_q[state_q];
		end
		if (done_s1 && !is_tick) begin
			table_mem[row_s1][col_s1] <= val_s1;
		end
		if (done_s1 && is_tick && moved) begin
			stats_mem[state_q] <= stats_new;
		end
		if (done_s1) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= mds_pkg::NUM_W'(2);
			state_q      <= '0;
			tick_q       <= '0;
			begin_q      <= '0;
			busy_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
			stats_vld_q  <= '0;
		end else begin
			if (cfg_we) num_states_q <= cfg_wdata;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done_s1) begin
				busy_q <= 1'b0;
			end
			if (done_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (done_s1 && is_tick) begin
				state_q <= next_st;
				tick_q  <= tick_q + mds_pkg::POS_W'(1);
				if (moved) begin
					// open the next dwell at this tick
					begin_q              <= tick_q;
					stats_vld_q[state_q] <= 1'b1;
				end
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.current_state = out_q.current_state;
	assign rsp.dwell_done    = out_q.dwell_done;
	assign rsp.ended_state   = out_q.ended_state;
	assign rsp.dwell_start   = out_q.dwell_start;
	assign rsp.dwell_length  = out_q.dwell_length;
	assign rsp.event_count   = out_q.event_count;
	assign rsp.total_dwell   = out_q.total_dwell;

endmodule

`default_nettype wire

// ----- src/mds_checker.sv -----
`default_nettype none

module mds_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [mds_pkg::STATE_W-1:0] current_state,
	input logic                        dwell_done,
	input logic [mds_pkg::STATE_W-1:0] ended_state,
	input logic [mds_pkg::POS_W-1:0]   dwell_start,
	input logic [mds_pkg::POS_W-1:0]   dwell_length,
	input logic [mds_pkg::CNT_W-1:0]   event_count,
	input logic [mds_pkg::TOT_W-1:0]   total_dwell
);

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous still in flight");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(current_state) && $stable(dwell_done))
		else $error("stalled response changed");

	a_ended_differs: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && dwell_done |-> ended_state != current_state && event_count != '0)
		else $error("ended dwell reports no state change or zero count");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !dwell_done |-> ended_state == '0 && dwell_start == '0 &&
			dwell_length == '0 && event_count == '0 && total_dwell == '0)
		else $error("dwell fields set without an ended dwell");

endmodule

bind markov_dwell_simulator mds_checker u_mds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.current_state (rsp.current_state),
	.dwell_done    (rsp.dwell_done),
	.ended_state   (rsp.ended_state),
	.dwell_start   (rsp.dwell_start),
	.dwell_length  (rsp.dwell_length),
	.event_count   (rsp.event_count),
	.total_dwell   (rsp.total_dwell)
);

`default_nettype wire

// ----- test/markov_dwell_checker.sv -----
`timescale 1ns / 100ps

module markov_dwell_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [mds_pkg::NUM_W-1:0] cfg_wdata,
	mds_req_if                        req,
	mds_rsp_if                        rsp,
	output int                        failures,
	output int                        outstanding
);
	import mds_pkg::*;

	localparam int PRINT_LIMIT = 100;

	logic [NUM_W-1:0] num_cfg;
	state_t           chain_state;
	logic [POS_W-1:0] tick_count;
	logic [POS_W-1:0] dwell_origin;
	prob_t            trans_prob [MAX_STATES][MAX_STATES];
	logic [CNT_W-1:0] visit_count [MAX_STATES];
	logic [TOT_W-1:0] time_in_state [MAX_STATES];
	rsp_t             expected_rsp [$];

	task automatic flag_error(input string msg);
		failures++;
		if (failures <= PRINT_LIMIT)
			$display("%0t ERROR: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			flag_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// Advance the chain by one request and return the response it should produce.
	function automatic rsp_t step_chain(input logic kind, input logic [RAND_W-1:0] stay_r,
		input logic [RAND_W-1:0] jump_r, input state_t row, input state_t col,
		input prob_t value);
		rsp_t             res;
		int               in_use;
		int               i;
		state_t           from;
		state_t           to;
		logic [PROB_W:0]  twice_r;
		logic [PROB_W:0]  diag;
		logic [POS_W-1:0] span;
		logic [TOT_W:0]   sum;
		bit               found;
		res = '0;
		if (kind == KIND_LOAD) begin
			trans_prob[row][col] = value;
			res.current_state = chain_state;
			return res;
		end
		in_use = (num_cfg < 2) ? 2 : (num_cfg > MAX_STATES) ? MAX_STATES : int'(num_cfg);
		from = chain_state;
		diag = {1'b0, trans_prob[from][from]};
		twice_r = {1'b0, stay_r, 1'b0};
		if (twice_r + diag >= TWO_FRAC || twice_r <= diag) begin
			to = from;
		end else begin
			found = 1'b0;
			to = from;
			for (i = 0; i < in_use; i++) begin
				if (!found && i != int'(from) && trans_prob[from][i] >= {1'b0, jump_r}) begin
					to = state_t'(i);
					found = 1'b1;
				end
			end
			// nothing reached the random: take the last state in use other than this one
			if (!found)
				to = (int'(from) == in_use - 1) ? state_t'(in_use - 2) : state_t'(in_use - 1);
		end
		if (to != from) begin
			span = tick_count - dwell_origin;
			if (visit_count[from] != '1)
				visit_count[from] = visit_count[from] + 1'b1;
			sum = {1'b0, time_in_state[from]} + span;
			time_in_state[from] = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
			res.dwell_done = 1'b1;
			res.ended_state = from;
			res.dwell_start = dwell_origin;
			res.dwell_length = span;
			res.event_count = visit_count[from];
			res.total_dwell = time_in_state[from];
			dwell_origin = tick_count;
		end
		chain_state = to;
		tick_count = tick_count + 1'b1;
		res.current_state = to;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t predicted;
		if (!arst_n) begin
			num_cfg = NUM_W'(2);
			chain_state = '0;
			tick_count = '0;
			dwell_origin = '0;
			for (int r = 0; r < MAX_STATES; r++) begin
				visit_count[r] = '0;
				time_in_state[r] = '0;
				for (int c = 0; c < MAX_STATES; c++)
					trans_prob[r][c] = '0;
			end
			expected_rsp.delete();
			outstanding = 0;
		end else begin
			if (cfg_we)
				num_cfg = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					flag_error("response with no request pending");
				end else begin
					want = expected_rsp.pop_front();
					check_field("current_state", rsp.current_state, want.current_state);
					check_field("dwell_done", rsp.dwell_done, want.dwell_done);
					check_field("ended_state", rsp.ended_state, want.ended_state);
					check_field("dwell_start", rsp.dwell_start, want.dwell_start);
					check_field("dwell_length", rsp.dwell_length, want.dwell_length);
					check_field("event_count", rsp.event_count, want.event_count);
					check_field("total_dwell", rsp.total_dwell, want.total_dwell);
				end
			end
			if (req.valid && req.ready) begin
				predicted = step_chain(req.kind, req.stay_random, req.jump_random,
					req.load_row, req.load_col, req.load_value);
				expected_rsp.insert(expected_rsp.size(), predicted);
			end
			outstanding = expected_rsp.size();
		end
	end

endmodule

// ----- test/tb_markov_dwell_simulator.sv -----
`timescale 1ns / 100ps

module tb_markov_dwell_simulator;
	import mds_pkg::*;

	localparam int IDLE_LIMIT      = 2000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int NUM_PHASES      = 12;
	localparam logic [NUM_W-1:0] PHASE_STATES [NUM_PHASES] =
		'{4'd3, 4'd0, 4'd8, 4'd15, 4'd2, 4'd5, 4'd1, 4'd9, 4'd7, 4'd4, 4'd6, 4'd8};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [NUM_W-1:0] cfg_wdata;
	logic             req_taken = 1'b0;
	int               failures;
	int               outstanding;
	int               idle_cycles = 0;
	int               burst_left = 0;
	int               stall_left = 0;
	int               calm_left = 0;
	bit               calm = 1'b0;

	mds_req_if req_ch ();
	mds_rsp_if rsp_ch ();

	markov_dwell_simulator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	markov_dwell_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk)
		req_taken <= req_ch.valid && req_ch.ready;

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: stretches of steady acceptance alternate with stretches of random stalls.
	always @(negedge clk) begin
		if (calm_left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			calm_left = $urandom_range(50, 300);
		end
		calm_left--;
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic send_request(input logic kind, input logic [RAND_W-1:0] stay_r,
		input logic [RAND_W-1:0] jump_r, input state_t row, input state_t col,
		input prob_t value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.stay_random <= stay_r;
		req_ch.jump_random <= jump_r;
		req_ch.load_row <= row;
		req_ch.load_col <= col;
		req_ch.load_value <= value;
		do @(negedge clk); while (!req_taken);
	endtask

	task automatic load_entry(input state_t row, input state_t col, input prob_t value);
		send_request(KIND_LOAD, RAND_W'($urandom), RAND_W'($urandom), row, col, value);
	endtask

	task automatic tick_chain(input logic [RAND_W-1:0] stay_r, input logic [RAND_W-1:0] jump_r);
		send_request(KIND_TICK, stay_r, jump_r, state_t'($urandom), state_t'($urandom),
			prob_t'($urandom));
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic set_state_count(input logic [NUM_W-1:0] n);
		cfg_wdata <= n;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [RAND_W-1:0] rand_fraction();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return '1;
			2: return 16'h8000;
			default: return RAND_W'($urandom);
		endcase
	endfunction

	task automatic send_random_item();
		state_t row;
		state_t col;
		prob_t  value;
		if ($urandom_range(0, 99) < 85) begin
			tick_chain(rand_fraction(), rand_fraction());
		end else begin
			row = state_t'($urandom_range(0, 7));
			// favor the diagonal so sticky states get released again
			col = ($urandom_range(0, 2) == 0) ? row : state_t'($urandom_range(0, 7));
			case ($urandom_range(0, 9))
				7: value = prob_t'(65536);
				8: value = prob_t'($urandom_range(65537, 131071));
				9: value = $urandom_range(0, 1) ? prob_t'(0) : prob_t'(131071);
				default: value = prob_t'($urandom_range(0, 65536));
			endcase
			load_entry(row, col, value);
		end
	endtask

	initial begin
		int cum;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_TICK;
		req_ch.stay_random = '0;
		req_ch.jump_random = '0;
		req_ch.load_row = '0;
		req_ch.load_col = '0;
		req_ch.load_value = '0;
		rsp_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		set_state_count(4'd8);

		// Fill every row: stay chance below 1.0, cumulative jumps ending below 65535.
		for (int r = 0; r < MAX_STATES; r++) begin
			cum = 0;
			for (int c = 0; c < MAX_STATES; c++) begin
				if (c == r) begin
					load_entry(state_t'(r), state_t'(c), prob_t'($urandom_range(0, 65535)));
				end else begin
					cum += $urandom_range(0, 9362);
					load_entry(state_t'(r), state_t'(c), prob_t'(cum));
				end
			end
		end

		load_entry(3'd0, 3'd0, 17'd0);
		tick_chain(16'd0, 16'd0);             // stay on the lower bound
		tick_chain(16'hFFFF, 16'd0);          // leave for the first other state
		load_entry(3'd1, 3'd1, 17'd65536);
		tick_chain(16'hFFFF, 16'd0);
		tick_chain(16'd0, 16'd0);
		load_entry(3'd1, 3'd1, 17'h1FFFF);    // stay probability above 1.0
		tick_chain(16'd40000, 16'd0);
		load_entry(3'd1, 3'd1, 17'd2);
		tick_chain(16'hFFFF, 16'hFFFF);       // stay on the upper bound
		load_entry(3'd1, 3'd1, 17'd1);
		tick_chain(16'hFFFF, 16'hFFFF);       // no entry reaches: fall back to state 7
		load_entry(3'd7, 3'd0, 17'd12345);
		tick_chain(16'h8000, 16'd12345);      // entry equal to the random qualifies
		tick_chain(16'h8000, 16'hFFFF);
		tick_chain(16'h8000, 16'hFFFF);       // fallback from the last state goes one below
		tick_chain(16'h8000, 16'hFFFF);
		drain_results();

		// The first phase shrinks the chain below the present state.
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_state_count(PHASE_STATES[p]);
			repeat (ITEMS_PER_PHASE) send_random_item();
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
